[rtl/rv64e_pkg.sv]
// Shared types, codes and helper functions of the RV64 instruction executor.
package rv64e_pkg;

  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned CSR_COUNT = 4096;
  localparam int unsigned QDEPTH    = 4;

  localparam logic [63:0] START_RESET = 64'h0000_0000_8000_0000;
  localparam logic [63:0] STACK_RESET = 64'h0000_0000_8800_0000;
  localparam logic [1:0]  PRIV_MACHINE    = 2'd3;
  localparam logic [1:0]  PRIV_SUPERVISOR = 2'd1;
  localparam logic [1:0]  PRIV_USER       = 2'd0;

  localparam logic [11:0] CSR_SSTATUS = 12'h100;
  localparam logic [11:0] CSR_SIE     = 12'h104;
  localparam logic [11:0] CSR_SEPC    = 12'h141;
  localparam logic [11:0] CSR_MSTATUS = 12'h300;
  localparam logic [11:0] CSR_MIDELEG = 12'h303;
  localparam logic [11:0] CSR_MIE     = 12'h304;
  localparam logic [11:0] CSR_MEPC    = 12'h341;

  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_IMM32  = 7'h1b;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_AMO    = 7'h2f;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_REG32  = 7'h3b;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE  = 7'h00;
  localparam logic [6:0] F7_MUL   = 7'h01;
  localparam logic [6:0] F7_ALT   = 7'h20;
  localparam logic [6:0] F7_SRET  = 7'h08;
  localparam logic [6:0] F7_MRET  = 7'h18;
  localparam logic [6:0] F7_FENCE = 7'h09;

  // pending access codes: loads use funct3 + 1
  localparam logic [3:0] PEND_NONE      = 4'd0;
  localparam logic [3:0] PEND_LOAD_LAST = 4'd7;
  localparam logic [3:0] PEND_AMOADD_W  = 4'd8;
  localparam logic [3:0] PEND_AMOADD_D  = 4'd10;

  typedef enum logic [2:0] {
    KIND_RETIRED = 3'd0,
    KIND_READ    = 3'd1,
    KIND_WRITE   = 3'd2,
    KIND_ILLEGAL = 3'd3,
    KIND_HALTED  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] mem_address;
    logic [1:0]  access_size;
    logic [63:0] write_data;
    logic [63:0] next_pc;
    logic [1:0]  privilege;
    logic        last;
  } result_t;

  typedef struct packed {
    logic        we;
    logic [4:0]  addr;
    logic [63:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic        we;
    logic [11:0] addr;
    logic [63:0] data;
  } csr_wr_t;

  typedef struct packed {
    logic [63:0] sstatus;
    logic [63:0] sepc;
    logic [63:0] mstatus;
    logic [63:0] mepc;
  } csr_view_t;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] size_mask(input logic [1:0] size);
    logic [63:0] m;
    case (size)
      2'd0:    m = 64'h0000_0000_0000_00ff;
      2'd1:    m = 64'h0000_0000_0000_ffff;
      2'd2:    m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  // extend load data per funct3: bit 2 set means unsigned
  function automatic logic [63:0] load_ext(input logic [63:0] d, input logic [2:0] f3);
    logic [63:0] v;
    case (f3)
      3'd0:    v = {{56{d[7]}}, d[7:0]};
      3'd1:    v = {{48{d[15]}}, d[15:0]};
      3'd2:    v = {{32{d[31]}}, d[31:0]};
      3'd4:    v = {56'd0, d[7:0]};
      3'd5:    v = {48'd0, d[15:0]};
      3'd6:    v = {32'd0, d[31:0]};
      default: v = d;
    endcase
    return v;
  endfunction

endpackage

[rtl/rv64e_in_if.sv]
// Input channel interface: instruction words and returning read data.
interface rv64e_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] instruction;
  logic [63:0] read_data;

  modport source(output valid, output operation, output instruction, output read_data,
                 input ready);
  modport sink(input valid, input operation, input instruction, input read_data,
               output ready);
endinterface

[rtl/rv64e_out_if.sv]
// Result channel interface: retirement, memory requests and status.
interface rv64e_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] mem_address;
  logic [1:0]  access_size;
  logic [63:0] write_data;
  logic [63:0] next_pc;
  logic [1:0]  privilege;
  logic        last;

  modport source(output valid, output kind, output mem_address, output access_size,
                 output write_data, output next_pc, output privilege, output last,
                 input ready);
  modport sink(input valid, input kind, input mem_address, input access_size,
               input write_data, input next_pc, input privilege, input last,
               output ready);
endinterface

[rtl/rv64e_regfile.sv]
// Integer register file: 32 x 64 memory, two registered read ports, one write port.
module rv64e_regfile import rv64e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rd_en,
  input  logic [4:0]  raddr_a,
  input  logic [4:0]  raddr_b,
  input  rf_wr_t      wr,
  input  logic        x2_load,
  input  logic [63:0] stack_top,
  output logic [63:0] rdata_a,
  output logic [63:0] rdata_b
);

  logic [63:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;
  logic [63:0]          qa_r, qb_r;
  logic [4:0]           ia_r, ib_r;
  logic                 va_r, vb_r;

  always_ff @(posedge clk) begin
    if (wr.we && wr.addr != 5'd0) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      qa_r <= mem[raddr_a];
      qb_r <= mem[raddr_b];
      ia_r <= raddr_a;
      ib_r <= raddr_b;
      va_r <= valid_r[raddr_a];
      vb_r <= valid_r[raddr_b];
    end
  end

  // entries never written since reset read their reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (wr.we && wr.addr != 5'd0) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (x2_load) begin
        valid_r[2] <= 1'b0;
      end
    end
  end

  always_comb begin
    if (ia_r == 5'd0)      rdata_a = '0;
    else if (va_r)         rdata_a = qa_r;
    else if (ia_r == 5'd2) rdata_a = stack_top;
    else                   rdata_a = '0;
    if (ib_r == 5'd0)      rdata_b = '0;
    else if (vb_r)         rdata_b = qb_r;
    else if (ib_r == 5'd2) rdata_b = stack_top;
    else                   rdata_b = '0;
  end

endmodule

[rtl/rv64e_csr.sv]
// CSR store: 4096-entry memory with clearing pass, trap CSRs held in flops.
module rv64e_csr import rv64e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rd_en,
  input  logic [11:0] raddr,
  input  csr_wr_t     wr,
  output logic [63:0] rdata,
  output csr_view_t   view,
  output logic        clearing
);

  logic [63:0] mem [CSR_COUNT];
  logic [63:0] q_r;
  logic [11:0] addr_r;
  logic [11:0] clr_idx_r;
  logic        clearing_r;
  logic [63:0] sstatus_r, sepc_r, mstatus_r, mideleg_r, mie_r, mepc_r;
  logic        wr_special;

  always_comb begin
    wr_special = (wr.addr == CSR_SSTATUS) || (wr.addr == CSR_SIE) ||
                 (wr.addr == CSR_SEPC) || (wr.addr == CSR_MSTATUS) ||
                 (wr.addr == CSR_MIDELEG) || (wr.addr == CSR_MIE) ||
                 (wr.addr == CSR_MEPC);
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr.we && !wr_special) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      q_r    <= mem[raddr];
      addr_r <= raddr;
    end
  end

  // sweep every entry to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + 12'd1;
      if (clr_idx_r == 12'hfff) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sstatus_r <= '0;
      sepc_r    <= '0;
      mstatus_r <= '0;
      mideleg_r <= '0;
      mie_r     <= '0;
      mepc_r    <= '0;
    end else if (wr.we) begin
      case (wr.addr)
        CSR_SSTATUS: sstatus_r <= wr.data;
        CSR_SIE:     mie_r     <= (mie_r & ~mideleg_r) | (wr.data & mideleg_r);
        CSR_SEPC:    sepc_r    <= wr.data;
        CSR_MSTATUS: mstatus_r <= wr.data;
        CSR_MIDELEG: mideleg_r <= wr.data;
        CSR_MIE:     mie_r     <= wr.data;
        CSR_MEPC:    mepc_r    <= wr.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (addr_r)
      CSR_SSTATUS: rdata = sstatus_r;
      CSR_SIE:     rdata = mie_r & mideleg_r;
      CSR_SEPC:    rdata = sepc_r;
      CSR_MSTATUS: rdata = mstatus_r;
      CSR_MIDELEG: rdata = mideleg_r;
      CSR_MIE:     rdata = mie_r;
      CSR_MEPC:    rdata = mepc_r;
      default:     rdata = q_r;
    endcase
  end

  assign view.sstatus = sstatus_r;
  assign view.sepc    = sepc_r;
  assign view.mstatus = mstatus_r;
  assign view.mepc    = mepc_r;
  assign clearing     = clearing_r;

endmodule

[rtl/rv64e_outq.sv]
// Result queue: takes up to two results a cycle, hands out one beat a cycle while the receiver is ready.
module rv64e_outq import rv64e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  push_cnt,
  input  result_t     push0,
  input  result_t     push1,
  output logic [2:0]  count,
  rv64e_out_if.source out_chan
);

  result_t    entries [QDEPTH];
  logic [1:0] head_r, tail_r;
  logic [2:0] count_r;
  logic       pop;
  result_t    head;

  assign pop = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entries[tail_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      entries[tail_r + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      tail_r  <= tail_r + push_cnt;
      head_r  <= head_r + {1'b0, pop};
      count_r <= count_r + {1'b0, push_cnt} - {2'b0, pop};
    end
  end

  assign head                 = entries[head_r];
  assign count                = count_r;
  assign out_chan.valid       = (count_r != 3'd0);
  assign out_chan.kind        = head.kind;
  assign out_chan.mem_address = head.mem_address;
  assign out_chan.access_size = head.access_size;
  assign out_chan.write_data  = head.write_data;
  assign out_chan.next_pc     = head.next_pc;
  assign out_chan.privilege   = head.privilege;
  assign out_chan.last        = head.last;

endmodule

[rtl/rv64_instruction_executor_top.sv]
// Top level of the RV64 instruction executor: decode, execute and write back.
// Flow: a beat is accepted, register file and CSR memory are read on that edge, and
// the execute stage then runs, writes back and queues its results; mul takes three
// steps through one 32x32 multiplier. A new beat is taken only once execute is idle.
// Reset: registers, pc and mode reload; the CSR memory is swept to zero, and during
// the sweep no input beat is taken (configuration writes are served throughout).
module rv64_instruction_executor_top import rv64e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rv64e_in_if.sink    in_chan,
  rv64e_out_if.source out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // architectural state outside the memories
  logic [63:0] pc_r, start_r, stack_top_r;
  logic [1:0]  priv_r;
  logic [3:0]  pend_r;
  logic [4:0]  pdest_r, psrc_r;
  logic [63:0] paddr_r;

  // execute stage
  logic        busy_r;
  logic        isdata_r;
  logic [31:0] inst_r;
  logic [63:0] data_r;
  logic [1:0]  mul_step_r;
  logic [63:0] acc_r;

  logic        in_accept, cfg_wr, exec_done, is_mul;
  logic [2:0]  q_count;
  logic        csr_clearing;
  logic [63:0] a, b, csr_rdata;
  csr_view_t   csr_view;
  rf_wr_t      rf_wr;
  csr_wr_t     csr_wr;

  logic [63:0] pc_nxt, pdaddr_nxt;
  logic [1:0]  priv_nxt;
  logic [3:0]  pend_nxt;
  logic [4:0]  pdest_nxt, psrc_nxt;
  result_t     res0, res1;
  logic [1:0]  push_cnt;

  // ---------------------------------------------------------------------------
  // Handshake: one item in execute at a time, no beat during the CSR clearing pass,
  // and the queue must have room for both results it may produce.
  // ---------------------------------------------------------------------------
  assign in_chan.ready = !busy_r && !csr_clearing && (q_count <= 3'd2);
  assign in_accept     = in_chan.valid && in_chan.ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[3] ? stack_top_r : start_r;

  rv64e_regfile u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .raddr_a  (in_chan.instruction[19:15]),
    .raddr_b  (in_chan.operation ? psrc_r : in_chan.instruction[24:20]),
    .wr       (rf_wr),
    .x2_load  (cfg_wr && paddr[3]),
    .stack_top(stack_top_r),
    .rdata_a  (a),
    .rdata_b  (b)
  );

  rv64e_csr u_csr (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .raddr   (in_chan.instruction[31:20]),
    .wr      (csr_wr),
    .rdata   (csr_rdata),
    .view    (csr_view),
    .clearing(csr_clearing)
  );

  rv64e_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_cnt(push_cnt),
    .push0   (res0),
    .push1   (res1),
    .count   (q_count),
    .out_chan(out_chan)
  );

  // ---------------------------------------------------------------------------
  // Capture the beat into the execute stage.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      isdata_r <= in_chan.operation;
      inst_r   <= in_chan.instruction;
      data_r   <= in_chan.read_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Field decode
  // ---------------------------------------------------------------------------
  logic [6:0]  opc, f7;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3;
  logic [63:0] imm_i, imm_s, imm_b, imm_u, imm_j, here, pc4;

  always_comb begin
    opc   = inst_r[6:0];
    rd    = inst_r[11:7];
    f3    = inst_r[14:12];
    rs1   = inst_r[19:15];
    rs2   = inst_r[24:20];
    f7    = inst_r[31:25];
    imm_i = {{52{inst_r[31]}}, inst_r[31:20]};
    imm_s = {{52{inst_r[31]}}, inst_r[31:25], inst_r[11:7]};
    imm_b = {{51{inst_r[31]}}, inst_r[31], inst_r[7], inst_r[30:25], inst_r[11:8], 1'b0};
    imm_u = sext32({inst_r[31:12], 12'd0});
    imm_j = {{43{inst_r[31]}}, inst_r[31], inst_r[19:12], inst_r[20], inst_r[30:21], 1'b0};
    here  = pc_r;
    pc4   = pc_r + 64'd4;
  end

  // ---------------------------------------------------------------------------
  // mul: low 64 bits built from three 32x32 partial products, one per cycle
  // ---------------------------------------------------------------------------
  logic [31:0] mop_a, mop_b;
  logic [63:0] prod, mul_res;

  assign is_mul = busy_r && !isdata_r && (pend_r == PEND_NONE) && (opc == OP_REG) &&
                  (f3 == 3'd0) && (f7 == F7_MUL);
  assign exec_done = busy_r && (!is_mul || mul_step_r == 2'd2);

  always_comb begin
    case (mul_step_r)
      2'd0:    begin mop_a = a[31:0];  mop_b = b[31:0];  end
      2'd1:    begin mop_a = a[31:0];  mop_b = b[63:32]; end
      default: begin mop_a = a[63:32]; mop_b = b[31:0];  end
    endcase
    prod    = {32'd0, mop_a} * {32'd0, mop_b};
    mul_res = acc_r + {prod[31:0], 32'd0};
  end

  always_ff @(posedge clk) begin
    if (is_mul && !exec_done) begin
      acc_r <= (mul_step_r == 2'd0) ? prod : mul_res;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute: compute next state, write-backs and the results of this item.
  // ---------------------------------------------------------------------------
  logic        illegal, fin, req0;
  logic [63:0] r, t, cnew, old, w, s_upd, m_upd;
  logic        take, dbl, add;
  logic [1:0]  mpp;

  always_comb begin
    pc_nxt     = pc_r;
    priv_nxt   = priv_r;
    pend_nxt   = pend_r;
    pdest_nxt  = pdest_r;
    psrc_nxt   = psrc_r;
    pdaddr_nxt = paddr_r;
    rf_wr      = '0;
    csr_wr     = '0;
    res0       = '0;
    res1       = '0;
    illegal    = 1'b0;
    fin        = 1'b0;
    req0       = 1'b0;
    r          = '0;
    t          = csr_rdata;
    cnew       = '0;
    old        = '0;
    w          = '0;
    take       = 1'b0;
    dbl        = 1'b0;
    add        = 1'b0;
    mpp        = '0;
    s_upd      = csr_view.sstatus;
    m_upd      = csr_view.mstatus;

    if (isdata_r) begin
      // returning read data; dropped when nothing waits for it
      if (pend_r != PEND_NONE) begin
        pend_nxt = PEND_NONE;
        fin      = 1'b1;
        if (pend_r <= PEND_LOAD_LAST) begin
          rf_wr = '{we: 1'b1, addr: pdest_r, data: load_ext(data_r, pend_r[2:0] - 3'd1)};
        end else begin
          dbl  = (pend_r >= PEND_AMOADD_D);
          add  = (pend_r == PEND_AMOADD_W) || (pend_r == PEND_AMOADD_D);
          old  = dbl ? data_r : sext32(data_r[31:0]);
          w    = (add ? old + b : b) & size_mask(dbl ? 2'd3 : 2'd2);
          req0 = 1'b1;
          res0.kind        = KIND_WRITE;
          res0.mem_address = paddr_r;
          res0.access_size = dbl ? 2'd3 : 2'd2;
          res0.write_data  = w;
          rf_wr = '{we: 1'b1, addr: pdest_r, data: old};
        end
      end
    end else if (pend_r == PEND_NONE) begin
      pc_nxt = pc4;
      fin    = 1'b1;
      case (opc)
        OP_LOAD: begin
          if (f3 == 3'd7) begin
            illegal = 1'b1;
          end else begin
            fin        = 1'b0;
            req0       = 1'b1;
            pend_nxt   = {1'b0, f3} + 4'd1;
            pdest_nxt  = rd;
            pdaddr_nxt = a + imm_i;
            res0.kind        = KIND_READ;
            res0.mem_address = a + imm_i;
            res0.access_size = f3[1:0];
            res0.last        = 1'b1;
          end
        end
        OP_IMM: begin
          case (f3)
            3'd0: r = a + imm_i;
            3'd1: r = a << imm_i[5:0];
            3'd2: r = {63'd0, $signed(a) < $signed(imm_i)};
            3'd3: r = {63'd0, a < imm_i};
            3'd4: r = a ^ imm_i;
            3'd5: begin
              if (f7[6:1] == 6'h00)      r = a >> imm_i[5:0];
              else if (f7[6:1] == 6'h10) r = $signed(a) >>> imm_i[5:0];
              else                       illegal = 1'b1;
            end
            3'd6: r = a | imm_i;
            default: r = a & imm_i;
          endcase
          rf_wr = '{we: 1'b1, addr: rd, data: r};
        end
        OP_AUIPC: rf_wr = '{we: 1'b1, addr: rd, data: here + imm_u};
        OP_LUI:   rf_wr = '{we: 1'b1, addr: rd, data: imm_u};
        OP_IMM32: begin
          if (f3 == 3'd0)                     r = a + imm_i;
          else if (f3 == 3'd1)                r = {32'd0, a[31:0]} << imm_i[4:0];
          else if (f3 == 3'd5 && f7 == F7_BASE) r = {32'd0, a[31:0]} >> imm_i[4:0];
          else if (f3 == 3'd5 && f7 == F7_ALT)
            r = $signed(sext32(a[31:0])) >>> imm_i[4:0];
          else                                illegal = 1'b1;
          rf_wr = '{we: 1'b1, addr: rd, data: sext32(r[31:0])};
        end
        OP_REG32: begin
          if (f3 == 3'd0 && f7 == F7_BASE)      r = a + b;
          else if (f3 == 3'd0 && f7 == F7_ALT)  r = a - b;
          else if (f3 == 3'd1)                  r = {32'd0, a[31:0]} << b[4:0];
          else if (f3 == 3'd5 && f7 == F7_BASE) r = {32'd0, a[31:0]} >> b[4:0];
          else if (f3 == 3'd5 && f7 == F7_ALT)
            r = $signed(sext32(a[31:0])) >>> b[4:0];
          else                                  illegal = 1'b1;
          rf_wr = '{we: 1'b1, addr: rd, data: sext32(r[31:0])};
        end
        OP_REG: begin
          case (f3)
            3'd0: begin
              if (f7 == F7_BASE)     r = a + b;
              else if (f7 == F7_MUL) r = mul_res;
              else if (f7 == F7_ALT) r = a - b;
              else                   illegal = 1'b1;
            end
            3'd1: r = a << b[5:0];
            3'd2: r = {63'd0, $signed(a) < $signed(b)};
            3'd3: r = {63'd0, a < b};
            3'd4: r = a ^ b;
            3'd5: begin
              if (f7 == F7_BASE)     r = a >> b[5:0];
              else if (f7 == F7_ALT) r = $signed(a) >>> b[5:0];
              else                   illegal = 1'b1;
            end
            3'd6: r = a | b;
            default: r = a & b;
          endcase
          rf_wr = '{we: 1'b1, addr: rd, data: r};
        end
        OP_STORE: begin
          if (f3 > 3'd3) begin
            illegal = 1'b1;
          end else begin
            req0 = 1'b1;
            res0.kind        = KIND_WRITE;
            res0.mem_address = a + imm_s;
            res0.access_size = f3[1:0];
            res0.write_data  = b & size_mask(f3[1:0]);
          end
        end
        OP_AMO: begin
          if ((f3 != 3'd2 && f3 != 3'd3) || f7[6:2] > 5'd1) begin
            illegal = 1'b1;
          end else begin
            fin        = 1'b0;
            req0       = 1'b1;
            pend_nxt   = PEND_AMOADD_W + {2'd0, f3[0], 1'b0} + {3'd0, f7[2]};
            pdest_nxt  = rd;
            psrc_nxt   = rs2;
            pdaddr_nxt = a;
            res0.kind        = KIND_READ;
            res0.mem_address = a;
            res0.access_size = f3[1:0];
            res0.last        = 1'b1;
          end
        end
        OP_BRANCH: begin
          case (f3)
            3'd0: take = (a == b);
            3'd1: take = (a != b);
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = $signed(a) >= $signed(b);
            3'd6: take = (a < b);
            3'd7: take = (a >= b);
            default: illegal = 1'b1;
          endcase
          if (take) pc_nxt = here + imm_b;
        end
        OP_JALR: begin
          pc_nxt = (a + imm_i) & ~64'd1;
          rf_wr  = '{we: 1'b1, addr: rd, data: pc4};
        end
        OP_JAL: begin
          pc_nxt = here + imm_j;
          rf_wr  = '{we: 1'b1, addr: rd, data: pc4};
        end
        OP_SYSTEM: begin
          case (f3)
            3'd0: begin
              if (f7 == F7_FENCE) begin
                // sfence.vma: nothing to flush
              end else if (rs2 != 5'd2) begin
                illegal = 1'b1;
              end else if (f7 == F7_SRET) begin
                pc_nxt   = csr_view.sepc;
                priv_nxt = csr_view.sstatus[8] ? PRIV_SUPERVISOR : PRIV_USER;
                s_upd[1] = csr_view.sstatus[5];
                s_upd[5] = 1'b1;
                s_upd[8] = 1'b0;
                csr_wr   = '{we: 1'b1, addr: CSR_SSTATUS, data: s_upd};
              end else if (f7 == F7_MRET) begin
                mpp      = csr_view.mstatus[12:11];
                pc_nxt   = csr_view.mepc;
                priv_nxt = (mpp == 2'd1) ? PRIV_SUPERVISOR :
                           ((mpp == 2'd0) ? PRIV_USER : PRIV_MACHINE);
                m_upd[3] = csr_view.mstatus[7];
                csr_wr   = '{we: 1'b1, addr: CSR_MSTATUS, data: m_upd};
              end
            end
            3'd4: illegal = 1'b1;
            default: begin
              case (f3)
                3'd1:    cnew = a;
                3'd2:    cnew = t | a;
                3'd3:    cnew = t & ~a;
                3'd5:    cnew = {59'd0, rs1};
                3'd6:    cnew = t | {59'd0, rs1};
                default: cnew = t & ~{59'd0, rs1};
              endcase
              csr_wr = '{we: 1'b1, addr: inst_r[31:20], data: cnew};
              rf_wr  = '{we: 1'b1, addr: rd, data: t};
            end
          endcase
        end
        default: illegal = 1'b1;
      endcase
      // an unknown encoding only advances pc and reports an illegal result
      if (illegal) begin
        rf_wr    = '0;
        csr_wr   = '0;
        req0     = 1'b0;
        fin      = 1'b1;
        pc_nxt   = pc4;
        priv_nxt = priv_r;
        pend_nxt = pend_r;
        pdest_nxt  = pdest_r;
        psrc_nxt   = psrc_r;
        pdaddr_nxt = paddr_r;
      end
    end

    // retirement beat goes after any memory request
    if (fin) begin
      if (req0) begin
        res1.kind = illegal ? KIND_ILLEGAL : ((pc_nxt == 64'd0) ? KIND_HALTED : KIND_RETIRED);
        res1.last = 1'b1;
      end else begin
        res0      = '0;
        res0.kind = illegal ? KIND_ILLEGAL : ((pc_nxt == 64'd0) ? KIND_HALTED : KIND_RETIRED);
        res0.last = 1'b1;
      end
    end
    res0.next_pc   = pc_nxt;
    res0.privilege = priv_nxt;
    res1.next_pc   = pc_nxt;
    res1.privilege = priv_nxt;

    push_cnt = {1'b0, req0} + {1'b0, fin};
    if (!exec_done) begin
      push_cnt  = '0;
      rf_wr.we  = 1'b0;
      csr_wr.we = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Commit and control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      mul_step_r  <= '0;
      pc_r        <= START_RESET;
      start_r     <= START_RESET;
      stack_top_r <= STACK_RESET;
      priv_r      <= PRIV_MACHINE;
      pend_r      <= PEND_NONE;
      pdest_r     <= '0;
      psrc_r      <= '0;
      paddr_r     <= '0;
    end else begin
      if (in_accept) begin
        busy_r <= 1'b1;
      end else if (exec_done) begin
        busy_r <= 1'b0;
      end
      if (exec_done) begin
        mul_step_r <= '0;
      end else if (is_mul) begin
        mul_step_r <= mul_step_r + 2'd1;
      end
      if (exec_done) begin
        pc_r    <= pc_nxt;
        priv_r  <= priv_nxt;
        pend_r  <= pend_nxt;
        pdest_r <= pdest_nxt;
        psrc_r  <= psrc_nxt;
        paddr_r <= pdaddr_nxt;
      end
      // the user must make configuration writes only while idle; the block does not enforce it
      if (cfg_wr) begin
        if (paddr[3]) begin
          stack_top_r <= pwdata;
        end else begin
          start_r <= pwdata;
          pc_r    <= pwdata;
        end
      end
    end
  end

endmodule
